/* sv/sent_crc4_pkg.sv */
// Package: constants, codes and GF(2) nibble arithmetic for the SENT CRC4 block.
`timescale 1ns / 1ps

package sent_crc4_pkg;

  typedef logic [3:0] nibble_t;
  typedef logic [1:0] crc_mode_t;

  // Generator x^4 + x^3 + x^2 + 1
  localparam logic [4:0] CRC_POLY = 5'h1D;
  localparam int WORD_NIBBLES = 8;

  // Mode codes
  localparam crc_mode_t MODE_LEGACY      = 2'd0;
  localparam crc_mode_t MODE_RECOMMENDED = 2'd1;
  localparam crc_mode_t MODE_ALTERNATIVE = 2'd2;

  // Register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SEED = 1'b1;

  localparam crc_mode_t MODE_RESET = MODE_RECOMMENDED;
  localparam nibble_t   SEED_RESET = 4'h5;

  // a * b mod P: carry-less 4x4 product, then three reduction steps
  function automatic nibble_t gf_mul(input nibble_t a, input nibble_t b);
    logic [6:0] p;
    p = '0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ ({3'b000, a} << i);
    end
    for (int k = 6; k >= 4; k--) begin
      if (p[k]) p = p ^ ({2'b00, CRC_POLY} << (k - 4));
    end
    return p[3:0];
  endfunction

  // x^j mod P for j = 0..6 (x has order 7 modulo P)
  function automatic nibble_t xpow(input logic [2:0] j);
    nibble_t r;
    case (j)
      3'd0:    r = 4'h1;
      3'd1:    r = 4'h2;
      3'd2:    r = 4'h4;
      3'd3:    r = 4'h8;
      3'd4:    r = 4'hD;
      3'd5:    r = 4'h7;
      3'd6:    r = 4'hE;
      default: r = 4'h1;
    endcase
    return r;
  endfunction

  // x^(4e) mod P for a nibble count e
  function automatic nibble_t x4pow(input logic [3:0] e);
    nibble_t r;
    case (e)
      4'd0, 4'd7, 4'd14:  r = 4'h1;
      4'd1, 4'd8, 4'd15:  r = 4'hD;
      4'd2, 4'd9:         r = 4'h2;
      4'd3, 4'd10:        r = 4'h7;
      4'd4, 4'd11:        r = 4'h4;
      4'd5, 4'd12:        r = 4'hE;
      4'd6, 4'd13:        r = 4'h8;
      default:            r = 4'h1;
    endcase
    return r;
  endfunction

endpackage

/* sv/sent_crc4_multi_mode_top.sv */
// Top level: SENT CRC4 checksum over seed, status and data nibbles, three modes.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive data_word, nibble_count and status_nibble with start
//   high; the transaction is taken at that rising edge (busy is always low, so
//   every start is taken). A new transaction may follow in every cycle.
//   Result channel: done pulses for one cycle with crc_value valid in that same
//   cycle. The receiver cannot stall; it must sample crc_value while done is high.
//   Timing: the command is captured in the input register, and crc_value and done
//   are set in the result register behind it, with no stall between the two.
//   Throughput: one frame per
//   cycle, set by the single combinational pass between those two registers.
//   The CRC is linear, so each counted nibble is scaled by a fixed power of x
//   modulo the generator in its own lane; one variable scale by x^(4e) then
//   aligns the seed part (in alternative mode also status and data), with e the
//   saturated nibble count (plus one outside legacy mode).
//   Configuration: cfg_wr_en with cfg_index 0 writes crc_mode, 1 writes crc_seed;
//   write only while no transaction is in flight.
//   Reset (rst, synchronous): drop any transaction in flight, clear done, and load
//   crc_mode = recommended, crc_seed = 5.
module sent_crc4_multi_mode_top #(
  parameter int MAX_NIBBLES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] data_word,
  input  logic [3:0]  nibble_count,
  input  logic [3:0]  status_nibble,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  output logic        done,
  output logic [3:0]  crc_value
);

  localparam logic [3:0] MAX_COUNT = 4'(MAX_NIBBLES);

  // Configuration registers
  sent_crc4_pkg::crc_mode_t crc_mode;
  sent_crc4_pkg::nibble_t   crc_seed;

  // Input register
  logic        in_valid;
  logic [31:0] data_q;
  logic [3:0]  count_q;
  logic [3:0]  status_q;

  // Lane terms
  sent_crc4_pkg::nibble_t right_term [MAX_NIBBLES];
  sent_crc4_pkg::nibble_t left_term  [MAX_NIBBLES];

  logic                   alt_mode;
  sent_crc4_pkg::nibble_t right_sum;
  sent_crc4_pkg::nibble_t left_sum;
  sent_crc4_pkg::nibble_t head;
  sent_crc4_pkg::nibble_t tail;
  logic [3:0]             exp_count;
  sent_crc4_pkg::nibble_t crc_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode <= sent_crc4_pkg::MODE_RESET;
      crc_seed <= sent_crc4_pkg::SEED_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sent_crc4_pkg::CFG_MODE: crc_mode <= cfg_wdata[1:0];
        sent_crc4_pkg::CFG_SEED: crc_seed <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the command, saturating the count
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    if (start) begin
      data_q   <= data_word;
      count_q  <= (nibble_count > MAX_COUNT) ? MAX_COUNT : nibble_count;
      status_q <= status_nibble;
    end
  end

  // Right-aligned lane g carries x^(4g); left-aligned lane g (nibble g+1)
  // carries x^(-4(g+1)) = x^(3(g+1) mod 7).
  for (genvar g = 0; g < MAX_NIBBLES; g++) begin : g_lane
    localparam logic [2:0] RJ = 3'((4 * g) % 7);
    localparam logic [2:0] LJ = 3'((3 * (g + 1)) % 7);
    logic lane_en;
    assign lane_en = (count_q > 4'(g));
    if (g < sent_crc4_pkg::WORD_NIBBLES) begin : g_word
      assign right_term[g] = lane_en ?
          sent_crc4_pkg::gf_mul(data_q[4*g +: 4], sent_crc4_pkg::xpow(RJ)) : 4'h0;
      assign left_term[g] = lane_en ?
          sent_crc4_pkg::gf_mul(data_q[31-4*g -: 4], sent_crc4_pkg::xpow(LJ)) : 4'h0;
    end else begin : g_zero
      // nibbles past the 32-bit word count as zero
      assign right_term[g] = 4'h0;
      assign left_term[g]  = 4'h0;
    end
  end

  always_comb begin
    right_sum = 4'h0;
    left_sum  = 4'h0;
    for (int i = 0; i < MAX_NIBBLES; i++) begin
      right_sum = right_sum ^ right_term[i];
      left_sum  = left_sum ^ left_term[i];
    end

    alt_mode = (crc_mode == sent_crc4_pkg::MODE_ALTERNATIVE);

    // crc = x^(4e) * head ^ tail
    case (crc_mode)
      sent_crc4_pkg::MODE_LEGACY: begin
        head      = crc_seed;
        tail      = right_sum;
        exp_count = count_q;
      end
      sent_crc4_pkg::MODE_ALTERNATIVE: begin
        head      = crc_seed ^ status_q ^ left_sum;
        tail      = 4'h0;
        exp_count = count_q + 4'd1;
      end
      default: begin
        // recommended, and the unused code: append a zero nibble
        head      = crc_seed;
        tail      = sent_crc4_pkg::gf_mul(right_sum, sent_crc4_pkg::xpow(3'd4));
        exp_count = count_q + 4'd1;
      end
    endcase

    crc_next = sent_crc4_pkg::gf_mul(head, sent_crc4_pkg::x4pow(exp_count)) ^
               (alt_mode ? 4'h0 : tail);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      crc_value <= crc_next;
    end
  end

endmodule

/* sim/sent_crc4_checker.sv */
// Checker: predicts the SENT CRC4 of each accepted frame and compares it with done/crc_value.
`timescale 1ns / 1ps

module sent_crc4_checker #(
  parameter int MAX_NIBBLES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] data_word,
  input  logic [3:0]  nibble_count,
  input  logic [3:0]  status_nibble,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  input  logic        done,
  input  logic [3:0]  crc_value,
  output int          fail_count,
  output int          pending_crcs
);

  sent_crc4_pkg::crc_mode_t mode_shadow;
  sent_crc4_pkg::nibble_t   seed_shadow;
  sent_crc4_pkg::nibble_t   crc_queue[$];
  int                       mismatch_total = 0;

  initial begin
    fail_count   = 0;
    pending_crcs = 0;
  end

  // Long division step: shift one nibble in MSB first, reduce by the generator.
  function automatic sent_crc4_pkg::nibble_t divide_nibble(input sent_crc4_pkg::nibble_t rem,
                                                           input sent_crc4_pkg::nibble_t nib);
    logic [4:0] r;
    r = {1'b0, rem};
    for (int b = 3; b >= 0; b--) begin
      r = {r[3:0], nib[b]};
      if (r[4]) r = r ^ sent_crc4_pkg::CRC_POLY;
    end
    return r[3:0];
  endfunction

  // Serial fold step: XOR the nibble in, then four reducing shifts.
  function automatic sent_crc4_pkg::nibble_t fold_nibble(input sent_crc4_pkg::nibble_t crc,
                                                         input sent_crc4_pkg::nibble_t nib);
    logic [4:0] t;
    t = {1'b0, crc ^ nib};
    for (int j = 0; j < 4; j++) begin
      t = {t[3:0], 1'b0};
      if (t[4]) t = t ^ sent_crc4_pkg::CRC_POLY;
    end
    return t[3:0];
  endfunction

  function automatic sent_crc4_pkg::nibble_t predict_crc(
      input logic [31:0] data, input logic [3:0] count,
      input sent_crc4_pkg::nibble_t status, input sent_crc4_pkg::crc_mode_t mode,
      input sent_crc4_pkg::nibble_t seed);
    int                     n;
    sent_crc4_pkg::nibble_t crc;
    sent_crc4_pkg::nibble_t nib;
    n = (count > MAX_NIBBLES) ? MAX_NIBBLES : int'(count);
    if (mode == sent_crc4_pkg::MODE_ALTERNATIVE) begin
      // left-aligned: first nibble sits in bits 31..28
      crc = fold_nibble(seed, status);
      for (int i = 1; i <= n; i++) begin
        nib = (i <= sent_crc4_pkg::WORD_NIBBLES) ? data[35 - 4 * i -: 4] : 4'h0;
        crc = fold_nibble(crc, nib);
      end
    end else begin
      // right-aligned: last nibble sits in bits 3..0
      crc = divide_nibble(4'h0, seed);
      for (int k = n - 1; k >= 0; k--) begin
        nib = (k < sent_crc4_pkg::WORD_NIBBLES) ? data[4 * k +: 4] : 4'h0;
        crc = divide_nibble(crc, nib);
      end
      if (mode != sent_crc4_pkg::MODE_LEGACY) crc = divide_nibble(crc, 4'h0);
    end
    return crc;
  endfunction

  always @(posedge clk) begin
    sent_crc4_pkg::nibble_t want_crc;
    if (rst) begin
      mode_shadow = sent_crc4_pkg::MODE_RESET;
      seed_shadow = sent_crc4_pkg::SEED_RESET;
      crc_queue.delete();
    end else begin
      if (done) begin
        if (crc_queue.size() == 0) begin
          $error("crc_value: no result expected, actual %0h", crc_value);
          mismatch_total++;
        end else begin
          want_crc = crc_queue.pop_front();
          if (crc_value !== want_crc) begin
            $error("crc_value mismatch: expected %0h, actual %0h", want_crc, crc_value);
            mismatch_total++;
          end
        end
      end
      if (start && !busy)
        crc_queue.push_back(predict_crc(data_word, nibble_count, status_nibble,
                                        mode_shadow, seed_shadow));
      if (cfg_wr_en) begin
        if (cfg_index == sent_crc4_pkg::CFG_MODE)
          mode_shadow = sent_crc4_pkg::crc_mode_t'(cfg_wdata[1:0]);
        else seed_shadow = cfg_wdata;
      end
    end
    fail_count   <= mismatch_total;
    pending_crcs <= crc_queue.size();
  end

endmodule

/* sim/tb_sent_crc4_multi_mode_top.sv */
// Testbench top: drives frames and register writes into the SENT CRC4 block and gives the verdict.
`timescale 1ns / 1ps

module tb_sent_crc4_multi_mode_top;

  localparam int MAX_NIBBLES = 8;
  // Mode code 3 is not defined; the block must treat it as recommended mode.
  localparam sent_crc4_pkg::crc_mode_t MODE_UNDEFINED = 2'd3;
  // Cycles to let pass after the last result before touching registers.
  localparam int SETTLE_CYCLES = 4;
  // Cycles with no transaction on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_PHASES = 10;
  localparam int FRAMES_PER_PHASE = 95;
  localparam int DIRECTED_FRAMES = 6;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] data_word;
  logic [3:0]  nibble_count;
  logic [3:0]  status_nibble;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [3:0]  cfg_wdata;
  logic        done;
  logic [3:0]  crc_value;
  int          fail_count;
  int          pending_crcs;
  int          idle_pct;
  int          stall_cycles;

  sent_crc4_multi_mode_top #(
    .MAX_NIBBLES(MAX_NIBBLES)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .data_word    (data_word),
    .nibble_count (nibble_count),
    .status_nibble(status_nibble),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .crc_value    (crc_value)
  );

  sent_crc4_checker #(
    .MAX_NIBBLES(MAX_NIBBLES)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .data_word    (data_word),
    .nibble_count (nibble_count),
    .status_nibble(status_nibble),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .crc_value    (crc_value),
    .fail_count   (fail_count),
    .pending_crcs (pending_crcs)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: abort when neither a frame nor a result moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Send one frame. Call and return on a rising edge; start stays high on return
  // so a following frame can go out back to back without a dip.
  task automatic send_frame(input logic [31:0] data, input logic [3:0] count,
                            input logic [3:0] status);
    // Random gaps: hold start low while the coin says idle.
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    data_word     <= data;
    nibble_count  <= count;
    status_nibble <= status;
    // Wait for the edge that takes the transaction.
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every predicted CRC has come back, then let the
  // pipeline settle so a register write cannot hit a frame in flight.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_crcs != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_wr_en high; the caller drops it after the last write.
  task automatic write_register(input logic idx, input logic [3:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input sent_crc4_pkg::crc_mode_t mode,
                                input sent_crc4_pkg::nibble_t seed);
    // Upper data bits of a mode write are don't-care; randomize them.
    write_register(sent_crc4_pkg::CFG_MODE, {2'($urandom_range(3)), mode});
    write_register(sent_crc4_pkg::CFG_SEED, seed);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0]              dir_data[DIRECTED_FRAMES];
    logic [3:0]               dir_count[DIRECTED_FRAMES];
    logic [3:0]               dir_status[DIRECTED_FRAMES];
    sent_crc4_pkg::crc_mode_t dir_modes[4];
    sent_crc4_pkg::crc_mode_t phase_mode;
    sent_crc4_pkg::nibble_t   phase_seed;
    logic [31:0]              rnd_data;
    logic [3:0]               rnd_count;
    int                       pick;

    // Corner frames: all zero, all ones, a count above the limit, data bits
    // outside the counted nibbles, a lone set nibble at each end, mid count.
    dir_data   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'h1234_5678, 32'h8000_0001, 32'hA5C3_0F96};
    dir_count  = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd4};
    dir_status = '{4'h0, 4'hF, 4'hA, 4'h5, 4'h0, 4'hC};
    // Reset settings first (recommended, seed 5), then the other modes.
    dir_modes  = '{sent_crc4_pkg::MODE_RESET, sent_crc4_pkg::MODE_LEGACY,
                   sent_crc4_pkg::MODE_ALTERNATIVE, MODE_UNDEFINED};

    rst           = 1'b1;
    start         = 1'b0;
    data_word     = '0;
    nibble_count  = '0;
    status_nibble = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = sent_crc4_pkg::CFG_MODE;
    cfg_wdata     = '0;
    idle_pct      = 20;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: run the corner frames under every mode, keeping the
    // reset seed so the reset values themselves get checked.
    foreach (dir_modes[m]) begin
      if (m != 0) begin
        drain();
        apply_settings(dir_modes[m], sent_crc4_pkg::SEED_RESET);
      end
      foreach (dir_data[i]) send_frame(dir_data[i], dir_count[i], dir_status[i]);
    end

    // Random part: each phase picks a register setting; the first four pin
    // the extremes of mode and seed, the rest are random.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          phase_mode = sent_crc4_pkg::MODE_LEGACY;
          phase_seed = 4'h0;
        end
        1: begin
          phase_mode = sent_crc4_pkg::MODE_ALTERNATIVE;
          phase_seed = 4'hF;
        end
        2: begin
          phase_mode = sent_crc4_pkg::MODE_RECOMMENDED;
          phase_seed = 4'hF;
        end
        3: begin
          phase_mode = MODE_UNDEFINED;
          phase_seed = 4'h0;
        end
        default: begin
          phase_mode = sent_crc4_pkg::crc_mode_t'($urandom_range(3));
          phase_seed = sent_crc4_pkg::nibble_t'($urandom_range(15));
        end
      endcase
      drain();
      apply_settings(phase_mode, phase_seed);
      // One phase runs back to back with no gaps at all.
      idle_pct = (p == 5) ? 0 : 20;

      for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        if (pick < 10) rnd_data = 32'hFFFF_FFFF;
        else if (pick < 15) rnd_data = 32'h0000_0000;
        else rnd_data = $urandom();
        // Mostly legal counts; some above the limit to exercise saturation.
        if ($urandom_range(99) < 10) rnd_count = 4'($urandom_range(15, MAX_NIBBLES + 1));
        else rnd_count = 4'($urandom_range(MAX_NIBBLES));
        send_frame(rnd_data, rnd_count, 4'($urandom_range(15)));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
